// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the max-heap priority queue.
// Included by mhpq_ctrl, which checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER_AT(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER_AT(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== sv/mhpq_pkg.sv =====
// Package of the max-heap priority queue: payload structs, operation and status codes,
// default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  // Default storage sizes.
  localparam int unsigned DEF_CAPACITY   = 64;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  // Fixed field widths of the channels.
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 7;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_e;

  typedef struct packed {
    func_e                     func;
    logic signed [VALUE_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        entry_count;
    logic                      is_empty;
    status_e                   status;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/mhpq_mem.sv =====
// Heap storage of the priority queue: one write port, two read ports,
// read data registered. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== sv/mhpq_ctrl.sv =====
// Sift engine of the priority queue: sequences push and pop over the heap memory,
// tracks the fill count and root, and holds the result register. Uses mhpq_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mhpq_ctrl
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire in_t                         in_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output out_t                             out_o,
  output logic                             mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_waddr_o,
  output logic [DATA_WIDTH-1:0]            mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr_a_o,
  output logic [$clog2(CAPACITY)-1:0]      mem_raddr_b_o,
  input  wire logic [DATA_WIDTH-1:0]       mem_rdata_a_i,
  input  wire logic [DATA_WIDTH-1:0]       mem_rdata_b_i
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0]       CapCnt  = CntW'(CAPACITY);
  localparam logic [DATA_WIDTH-1:0] SignBit = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_LOAD,
    S_DOWN,
    S_DOWN_CMP,
    S_FIN
  } state_e;

  state_e                 state_q, state_d;
  logic [CntW-1:0]        fill_q, fill_d;
  status_e                status_q, status_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;
  logic [AddrW-1:0]       pos_q, pos_d;
  logic [DATA_WIDTH-1:0]  cur_q, cur_d;
  logic                   r_ok_q, r_ok_d;
  logic [DATA_WIDTH-1:0]  top_key_q;

  logic signed [DATA_WIDTH-1:0] in_sval;
  logic [DATA_WIDTH-1:0]        in_key;
  logic signed [DATA_WIDTH-1:0] top_sval;
  logic [AddrW-1:0]             parent_idx;
  logic [AddrW-1:0]             last_idx;
  logic [AddrW+1:0]             child_l;
  logic [AddrW+1:0]             child_r;
  logic [AddrW+1:0]             fill_ext;
  logic                         r_in;
  logic                         pick_r;
  logic [DATA_WIDTH-1:0]        child_key;
  logic [AddrW-1:0]             child_idx;
  logic                         load_out;

  // Keys carry the sign bit flipped so that an unsigned compare orders signed values.
  assign in_sval  = DATA_WIDTH'(in_i.value);
  assign in_key   = in_sval ^ SignBit;
  assign top_sval = top_key_q ^ SignBit;

  // Heap index arithmetic around the current position.
  assign parent_idx = AddrW'((pos_q - 1'b1) >> 1);
  assign last_idx   = AddrW'(fill_q - 1'b1);
  assign child_l    = {1'b0, pos_q, 1'b1};
  assign child_r    = child_l + (AddrW+2)'(1);
  assign fill_ext   = (AddrW+2)'(fill_q);
  assign r_in       = child_r < fill_ext;

  // Larger child; the right one wins only when strictly greater.
  assign pick_r    = r_ok_q && (mem_rdata_b_i > mem_rdata_a_i);
  assign child_key = pick_r ? mem_rdata_b_i : mem_rdata_a_i;
  assign child_idx = pick_r ? AddrW'(child_r) : AddrW'(child_l);

  // Next-state and memory port control.
  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    status_d      = status_q;
    pos_d         = pos_q;
    cur_d         = cur_q;
    r_ok_d        = r_ok_q;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = cur_q;
    mem_raddr_a_o = parent_idx;
    mem_raddr_b_o = parent_idx;
    load_out      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          status_d = ST_OK;
          if (in_i.func == FUNC_PUSH) begin
            if (fill_q == CapCnt) begin
              status_d = ST_PUSH_FULL;
              state_d  = S_FIN;
            end else begin
              cur_d   = in_key;
              pos_d   = AddrW'(fill_q);
              fill_d  = fill_q + 1'b1;
              state_d = S_UP;
            end
          end else begin
            if (fill_q == '0) begin
              status_d = ST_POP_EMPTY;
              state_d  = S_FIN;
            end else begin
              // Fetch the last entry; it will sink from the root.
              fill_d        = fill_q - 1'b1;
              mem_raddr_a_o = last_idx;
              pos_d         = '0;
              state_d       = (fill_q == CntW'(1)) ? S_FIN : S_LOAD;
            end
          end
        end
      end
      S_UP: begin
        if (pos_q == '0) begin
          mem_we_o = 1'b1;
          state_d  = S_FIN;
        end else begin
          mem_raddr_a_o = parent_idx;
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we_o = 1'b1;
        if (cur_q > mem_rdata_a_i) begin
          // Parent moves down; the new value keeps climbing.
          mem_wdata_o = mem_rdata_a_i;
          pos_d       = parent_idx;
          state_d     = S_UP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LOAD: begin
        cur_d   = mem_rdata_a_i;
        state_d = S_DOWN;
      end
      S_DOWN: begin
        if (child_l >= fill_ext) begin
          mem_we_o = 1'b1;
          state_d  = S_FIN;
        end else begin
          mem_raddr_a_o = AddrW'(child_l);
          mem_raddr_b_o = r_in ? AddrW'(child_r) : AddrW'(child_l);
          r_ok_d        = r_in;
          state_d       = S_DOWN_CMP;
        end
      end
      S_DOWN_CMP: begin
        mem_we_o = 1'b1;
        if (child_key > cur_q) begin
          // Larger child moves up; the sinking entry goes one level down.
          mem_wdata_o = child_key;
          pos_d       = child_idx;
          state_d     = S_DOWN;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result assembled from the count and the cached root.
  always_comb begin
    out_d.top_value   = (fill_q != '0) ? VALUE_W'(top_sval) : '0;
    out_d.entry_count = COUNT_W'(fill_q);
    out_d.is_empty    = (fill_q == '0);
    out_d.status      = status_q;
    out_valid_d       = load_out || (out_valid_q && !out_ready_i);
  end

  // State, count and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      status_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
      if (load_out) begin
        out_q <= out_d;
      end
    end
  end

  // Working registers of the sift and the cached root entry.
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    cur_q  <= cur_d;
    r_ok_q <= r_ok_d;
    if (mem_we_o && (mem_waddr_o == '0)) begin
      top_key_q <= mem_wdata_o;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // Checks on the sift engine.
  `ASSERT_AT(a_fill_bound, clk_i, rst_ni, fill_q <= CapCnt, "fill count exceeds capacity")
  `ASSERT_AT(a_write_in_range, clk_i, rst_ni, mem_we_o |-> (CntW'(mem_waddr_o) < fill_q), "heap write beyond the fill count")
  `ASSERT_AT(a_result_from_fin, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_FIN), "result loaded outside the finish step")
  `ASSERT_NEVER_AT(a_up_not_root, clk_i, rst_ni, (state_q == S_UP_CMP) && (pos_q == '0), "sift-up compare at the root")

endmodule

`default_nettype wire

// ===== sv/max_heap_priority_queue_top.sv =====
// Top level of the max-heap priority queue: sift engine plus heap memory.
// Depends on mhpq_pkg, mhpq_mem and mhpq_ctrl.
//
//  Channel   Direction  Handshake              Payload
//  input     in         in_valid_i/in_ready_o  in_i  (func, value)
//  result    out        out_valid_o/out_ready_i out_o (top_value, entry_count, is_empty, status)
//
// An item that moves no entry (dropped push, ignored pop, pop of the last entry) goes from
// idle straight to the finish step. A push climbs and a pop, after loading the last entry,
// sinks one heap level at a time: each level costs a memory read step and a
// compare-and-write step on the single heap memory.
// Reset clears the fill count and the control state; the memory needs no clearing.
// While a result waits, the engine still takes one more item, which holds in its finish step
// until the result register is free; input stalls meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module max_heap_priority_queue_top
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY   = DEF_CAPACITY,
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_o
);

  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic                  mem_we;
  logic [AddrW-1:0]      mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [AddrW-1:0]      mem_raddr_a;
  logic [AddrW-1:0]      mem_raddr_b;
  logic [DATA_WIDTH-1:0] mem_rdata_a;
  logic [DATA_WIDTH-1:0] mem_rdata_b;

  // Sift sequencer and result register.
  mhpq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (out_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  // Heap storage.
  mhpq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule

`default_nettype wire

// ===== dv/mhpq_heap_monitor.sv =====
// Heap monitor for the max-heap priority queue: watches both channels, keeps its own heap,
// and compares every result transfer against the oldest predicted report.
// Depends on mhpq_pkg for the payload structs and the operation and status codes.
`timescale 1ns / 1ps

module mhpq_heap_monitor
  import mhpq_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_i,
  output int   err_count_o,
  output int   pending_o
);

  // Shadow heap: slot i has children 2i+1 and 2i+2.
  logic signed [VALUE_W-1:0] heap_slots [CAPACITY];
  int                        heap_fill;
  out_t                      pending_reports [$];
  int                        mismatches = 0;

  // Applies one operation to the shadow heap and returns the report it should produce.
  function automatic out_t heap_apply(in_t item);
    out_t                      report;
    status_e                   st;
    int                        pos;
    int                        parent;
    int                        best;
    int                        left;
    int                        right;
    logic signed [VALUE_W-1:0] tmp;
    st = ST_OK;
    if (item.func == FUNC_PUSH) begin
      if (heap_fill >= CAPACITY) begin
        st = ST_PUSH_FULL;
      end else begin
        // Append and sift up while strictly greater than the parent.
        heap_slots[heap_fill] = item.value;
        pos = heap_fill;
        heap_fill++;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (heap_slots[pos] > heap_slots[parent]) begin
            tmp = heap_slots[pos];
            heap_slots[pos] = heap_slots[parent];
            heap_slots[parent] = tmp;
            pos = parent;
          end else begin
            break;
          end
        end
      end
    end else begin
      if (heap_fill == 0) begin
        st = ST_POP_EMPTY;
      end else begin
        // Move the last entry to the root and sift down; the left child wins a tie.
        heap_slots[0] = heap_slots[heap_fill - 1];
        heap_fill--;
        pos = 0;
        while (pos < heap_fill) begin
          best = pos;
          left = 2 * pos + 1;
          right = 2 * pos + 2;
          if (left < heap_fill && heap_slots[left] > heap_slots[best]) best = left;
          if (right < heap_fill && heap_slots[right] > heap_slots[best]) best = right;
          if (best == pos) break;
          tmp = heap_slots[pos];
          heap_slots[pos] = heap_slots[best];
          heap_slots[best] = tmp;
          pos = best;
        end
      end
    end
    report.top_value   = (heap_fill != 0) ? heap_slots[0] : '0;
    report.entry_count = COUNT_W'(heap_fill);
    report.is_empty    = (heap_fill == 0);
    report.status      = st;
    return report;
  endfunction

  // Predict on each input transfer, compare on each result transfer.
  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      heap_fill = 0;
      pending_reports.delete();
      pending_o <= 0;
      err_count_o <= mismatches;
    end else begin
      if (in_valid_i && in_ready_i) begin
        pending_reports = {pending_reports, heap_apply(in_i)};
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("result transfer with no prediction waiting");
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          if (out_i.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, out_i.top_value);
            mismatches++;
          end
          if (out_i.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_i.entry_count);
            mismatches++;
          end
          if (out_i.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0b, got %0b", want.is_empty, out_i.is_empty);
            mismatches++;
          end
          if (out_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_i.status);
            mismatches++;
          end
        end
      end
      pending_o <= pending_reports.size();
      err_count_o <= mismatches;
    end
  end

endmodule

// ===== dv/tb_max_heap_priority_queue_top.sv =====
// Testbench top for the max-heap priority queue: drives push and pop traffic with random
// gaps and stalls, and gives the verdict. Depends on mhpq_pkg, the queue top level and
// mhpq_heap_monitor.
`timescale 1ns / 1ps

module tb_max_heap_priority_queue_top;
  import mhpq_pkg::*;

  localparam int unsigned ITEM_TARGET    = 700;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AT_RESULT = 40;
  localparam int unsigned SETTLE_CYCLES  = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        req_valid;
  logic        req_ready;
  in_t         req_item;
  logic        rsp_valid;
  logic        rsp_ready;
  out_t        rsp_item;
  int          errors;
  int          outstanding;
  int unsigned sent = 0;
  int unsigned received = 0;
  int unsigned cycles = 0;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  max_heap_priority_queue_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_i       (req_item),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_o      (rsp_item)
  );

  mhpq_heap_monitor u_monitor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_valid),
    .in_ready_i (req_ready),
    .in_i       (req_item),
    .out_valid_i(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_i      (rsp_item),
    .err_count_o(errors),
    .pending_o  (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Values lean toward the extremes and toward a narrow band that produces ties.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      1, 2:    return int'($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and returns at the edge of its transfer.
  task automatic send_op(func_e op, logic signed [VALUE_W-1:0] val);
    int unsigned gap;
    if (sent % 40 == 0) send_idle = ($urandom_range(0, 2) != 0);
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid <= 1'b1;
    req_item  <= '{func: op, value: val};
    @(posedge clk_i);
    while (!req_ready) @(posedge clk_i);
    sent++;
  endtask

  // Stops offering and waits until every predicted report has arrived.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls per result, with one long hold-off to back the queue up.
  initial begin
    int unsigned stall;
    rsp_ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (received % 40 == 0) recv_idle = ($urandom_range(0, 2) != 0);
      stall = recv_idle ? $urandom_range(0, 6) : 0;
      if (received == HOLD_AT_RESULT) stall = LONG_HOLD;
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_valid) @(posedge clk_i);
      received++;
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned pop_pct;
    int unsigned len;
    req_valid <= 1'b0;
    req_item  <= '{func: FUNC_PUSH, value: '0};
    rst_ni    <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty, extreme values, ties at the top and among children.
    send_op(FUNC_POP, 32'sh1234_5678);
    send_op(FUNC_PUSH, 32'sh0);
    send_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    send_op(FUNC_PUSH, 32'sh8000_0000);
    send_op(FUNC_PUSH, -32'sd1);
    send_op(FUNC_PUSH, 32'sd1);
    send_op(FUNC_PUSH, 32'sh7FFF_FFFF);
    send_op(FUNC_PUSH, 32'sd5);
    send_op(FUNC_PUSH, 32'sd5);
    for (int i = 0; i < 8; i++) send_op(FUNC_POP, pick_value());
    send_op(FUNC_POP, 32'shFFFF_FFFF);
    send_op(FUNC_PUSH, 32'sh8000_0000);
    send_op(FUNC_POP, 32'sh0);
    wait_drained();

    // Fill past capacity so that pushes get dropped, then drain past empty.
    for (int i = 0; i < 70; i++) send_op(FUNC_PUSH, pick_value());
    wait_drained();
    for (int i = 0; i < 70; i++) send_op(FUNC_POP, pick_value());

    // Random phases that lean toward filling, draining, or neither.
    while (sent < ITEM_TARGET) begin
      case ($urandom_range(0, 2))
        0:       pop_pct = 15;
        1:       pop_pct = 85;
        default: pop_pct = 50;
      endcase
      len = $urandom_range(20, 80);
      for (int i = 0; i < len && sent < ITEM_TARGET; i++) begin
        send_op(($urandom_range(0, 99) < pop_pct) ? FUNC_POP : FUNC_PUSH, pick_value());
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
